>>> rtl/rwnh_pkg.sv
// Shared types, widths and codes of the ray to wall nearest hit block.
// Used by every module of the block; depends on nothing.
package rwnh_pkg;

	localparam int MAX_WALLS_DEFAULT = 16;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_CAST = 1'b1;

	localparam int COORD_W   = 10;
	localparam int Q8_W      = 18;
	localparam int DIR_W     = 16;
	localparam int CFG_W     = 5;
	localparam int WALL_ID_W = 4;
	localparam int WALL_W    = 4 * COORD_W;

	// Magnitudes after the sign of the denominator has been folded in.
	localparam int DEN_W     = 27;
	localparam int NW_W      = 35;
	localparam int NR_W      = 29;

	localparam int DIV_NUM_W = 47;
	localparam int DIV_Q_W   = 19;

	localparam int S_TDATA_W = 144;
	localparam int M_TDATA_W = 64;

	localparam logic [Q8_W-1:0] Q8_MAX = '1;

	// One finished wall walk, handed from the front to the back.
	typedef struct packed {
		logic                     found;
		logic [WALL_ID_W-1:0]     wall;
		logic [COORD_W-1:0]       x1;
		logic [COORD_W-1:0]       y1;
		logic signed [COORD_W:0]  ex;
		logic signed [COORD_W:0]  ey;
		logic [NR_W-1:0]          nr;
		logic [NW_W-1:0]          nw;
		logic [DEN_W-1:0]         den;
		logic signed [DIR_W-1:0]  dx;
		logic signed [DIR_W-1:0]  dy;
		logic signed [DIR_W-1:0]  vx;
		logic signed [DIR_W-1:0]  vy;
	} job_t;

	typedef struct packed {
		logic               done;
		logic               ovf;
		logic               rem_nz;
		logic [DIV_Q_W-1:0] quo;
	} div_res_t;

endpackage

>>> rtl/rwnh_front.sv
// Front end: takes load and cast transactions, holds the wall table and walks
// the walls of a cast to find the nearest hit. Depends on rwnh_pkg.
module rwnh_front #(
	parameter int MAX_WALLS = rwnh_pkg::MAX_WALLS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rwnh_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  logic [rwnh_pkg::CFG_W-1:0]     walls_in_use,
	output rwnh_pkg::job_t                 job,
	output logic                           job_push,
	input  logic                           queue_full
);

	localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int CNT_W = $clog2(MAX_WALLS + 1);

	localparam logic [1:0] FR_IDLE = 2'd0;
	localparam logic [1:0] FR_WALK = 2'd1;
	localparam logic [1:0] FR_PUSH = 2'd2;

	logic [1:0]       state_q;
	logic             phase_q;
	logic [CNT_W-1:0] issue_cnt_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cfg_cnt;

	logic accept, load_en, issue, drained, upd;
	logic [IDX_W-1:0] wr_addr;

	logic [rwnh_pkg::WALL_W-1:0] wall_mem [MAX_WALLS];

	logic [17:0]        ray_x_q, ray_y_q;
	logic signed [15:0] dx_q, dy_q, vx_q, vy_q;

	// Stage 1: table read.
	logic                        v_s1;
	logic [3:0]                  idx_s1;
	logic [rwnh_pkg::WALL_W-1:0] rd_s1;
	// Stage 2: edge and offset vectors.
	logic               v_s2;
	logic [3:0]         idx_s2;
	logic [9:0]         x1_s2, y1_s2;
	logic signed [10:0] ex_s2, ey_s2;
	logic signed [18:0] ox_s2, oy_s2;
	// Stage 3: products.
	logic               v_s3;
	logic [3:0]         idx_s3;
	logic [9:0]         x1_s3, y1_s3;
	logic signed [10:0] ex_s3, ey_s3;
	logic signed [26:0] dyex_s3, dxey_s3;
	logic signed [34:0] dxoy_s3, dyox_s3;
	logic signed [29:0] exoy_s3, eyox_s3;
	// Stage 4: numerators, denominator and hit test.
	logic                        cv_s4;
	logic [3:0]                  idx_s4;
	logic [9:0]                  x1_s4, y1_s4;
	logic signed [10:0]          ex_s4, ey_s4;
	logic [rwnh_pkg::NR_W-1:0]   nr_s4;
	logic [rwnh_pkg::NW_W-1:0]   nw_s4;
	logic [rwnh_pkg::DEN_W-1:0]  den_s4;
	// Stage 5: cross products against the best so far.
	logic                        cv_s5;
	logic [3:0]                  idx_s5;
	logic [9:0]                  x1_s5, y1_s5;
	logic signed [10:0]          ex_s5, ey_s5;
	logic [rwnh_pkg::NR_W-1:0]   nr_s5;
	logic [rwnh_pkg::NW_W-1:0]   nw_s5;
	logic [rwnh_pkg::DEN_W-1:0]  den_s5;
	logic [55:0]                 pa_s5, pb_s5;

	logic                        found_q;
	logic [3:0]                  best_idx_q;
	logic [9:0]                  best_x1_q, best_y1_q;
	logic signed [10:0]          best_ex_q, best_ey_q;
	logic [rwnh_pkg::NR_W-1:0]   best_nr_q;
	logic [rwnh_pkg::NW_W-1:0]   best_nw_q;
	logic [rwnh_pkg::DEN_W-1:0]  best_den_q;

	logic signed [27:0] den_w, den_f;
	logic signed [35:0] nw_w, nw_f, lim_w;
	logic signed [30:0] nr_w, nr_f;
	logic               cand_w;

	assign s_tready = (state_q == FR_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_en  = accept && (s_tuser == rwnh_pkg::FUNC_LOAD)
		&& (int'(s_tdata[3:0]) < MAX_WALLS);
	assign wr_addr  = IDX_W'(s_tdata[3:0]);
	assign cfg_cnt  = (int'(walls_in_use) > MAX_WALLS) ? CNT_W'(MAX_WALLS)
		: CNT_W'(walls_in_use);

	// Walls enter only while phase_q is low, so that a best update lands before the
	// next cross product reads it.
	assign issue   = (state_q == FR_WALK) && !phase_q && (issue_cnt_q < count_q);
	assign drained = (issue_cnt_q == count_q) && !v_s1 && !v_s2 && !v_s3
		&& !cv_s4 && !cv_s5;
	assign upd     = cv_s5 && (!found_q || (pa_s5 < pb_s5));

	always_ff @(posedge clk) begin
		if (load_en) begin
			wall_mem[wr_addr] <= s_tdata[43:4];
		end
		rd_s1 <= wall_mem[issue_cnt_q[IDX_W-1:0]];
	end

	always_comb begin
		den_w  = 28'(dyex_s3) - 28'(dxey_s3);
		nw_w   = 36'(dxoy_s3) - 36'(dyox_s3);
		nr_w   = 31'(exoy_s3) - 31'(eyox_s3);
		den_f  = den_w[27] ? -den_w : den_w;
		nw_f   = den_w[27] ? -nw_w : nw_w;
		nr_f   = den_w[27] ? -nr_w : nr_w;
		lim_w  = $signed({1'b0, den_f[26:0], 8'b0});
		cand_w = (den_w != 28'sd0) && (nw_f > 36'sd0) && (nw_f < lim_w)
			&& (nr_f > 31'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FR_IDLE;
			phase_q     <= 1'b0;
			issue_cnt_q <= '0;
			count_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			cv_s4       <= 1'b0;
			cv_s5       <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			cv_s4 <= v_s3 && cand_w;
			cv_s5 <= cv_s4;
			if (upd) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				FR_IDLE: begin
					if (accept && (s_tuser == rwnh_pkg::FUNC_CAST)) begin
						state_q     <= FR_WALK;
						phase_q     <= 1'b0;
						issue_cnt_q <= '0;
						count_q     <= cfg_cnt;
						found_q     <= 1'b0;
					end
				end
				FR_WALK: begin
					phase_q <= !phase_q;
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (drained) begin
						state_q <= FR_PUSH;
					end
				end
				FR_PUSH: begin
					if (!queue_full) begin
						state_q <= FR_IDLE;
					end
				end
				default: begin
					state_q <= FR_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == rwnh_pkg::FUNC_CAST)) begin
			ray_x_q <= s_tdata[61:44];
			ray_y_q <= s_tdata[79:62];
			dx_q    <= $signed(s_tdata[95:80]);
			dy_q    <= $signed(s_tdata[111:96]);
			vx_q    <= $signed(s_tdata[127:112]);
			vy_q    <= $signed(s_tdata[143:128]);
		end
		idx_s1 <= 4'(issue_cnt_q);

		idx_s2 <= idx_s1;
		x1_s2  <= rd_s1[9:0];
		y1_s2  <= rd_s1[19:10];
		ex_s2  <= $signed({1'b0, rd_s1[29:20]}) - $signed({1'b0, rd_s1[9:0]});
		ey_s2  <= $signed({1'b0, rd_s1[39:30]}) - $signed({1'b0, rd_s1[19:10]});
		ox_s2  <= $signed({1'b0, rd_s1[9:0], 8'b0}) - $signed({1'b0, ray_x_q});
		oy_s2  <= $signed({1'b0, rd_s1[19:10], 8'b0}) - $signed({1'b0, ray_y_q});

		idx_s3  <= idx_s2;
		x1_s3   <= x1_s2;
		y1_s3   <= y1_s2;
		ex_s3   <= ex_s2;
		ey_s3   <= ey_s2;
		dyex_s3 <= dy_q * ex_s2;
		dxey_s3 <= dx_q * ey_s2;
		dxoy_s3 <= dx_q * oy_s2;
		dyox_s3 <= dy_q * ox_s2;
		exoy_s3 <= ex_s2 * oy_s2;
		eyox_s3 <= ey_s2 * ox_s2;

		idx_s4 <= idx_s3;
		x1_s4  <= x1_s3;
		y1_s4  <= y1_s3;
		ex_s4  <= ex_s3;
		ey_s4  <= ey_s3;
		nr_s4  <= nr_f[rwnh_pkg::NR_W-1:0];
		nw_s4  <= nw_f[rwnh_pkg::NW_W-1:0];
		den_s4 <= den_f[rwnh_pkg::DEN_W-1:0];

		idx_s5 <= idx_s4;
		x1_s5  <= x1_s4;
		y1_s5  <= y1_s4;
		ex_s5  <= ex_s4;
		ey_s5  <= ey_s4;
		nr_s5  <= nr_s4;
		nw_s5  <= nw_s4;
		den_s5 <= den_s4;
		pa_s5  <= nr_s4 * best_den_q;
		pb_s5  <= best_nr_q * den_s4;

		if (upd) begin
			best_idx_q <= idx_s5;
			best_x1_q  <= x1_s5;
			best_y1_q  <= y1_s5;
			best_ex_q  <= ex_s5;
			best_ey_q  <= ey_s5;
			best_nr_q  <= nr_s5;
			best_nw_q  <= nw_s5;
			best_den_q <= den_s5;
		end
	end

	assign job_push = (state_q == FR_PUSH) && !queue_full;

	always_comb begin
		job.found = found_q;
		job.wall  = best_idx_q;
		job.x1    = best_x1_q;
		job.y1    = best_y1_q;
		job.ex    = best_ex_q;
		job.ey    = best_ey_q;
		job.nr    = best_nr_q;
		job.nw    = best_nw_q;
		job.den   = best_den_q;
		job.dx    = dx_q;
		job.dy    = dy_q;
		job.vx    = vx_q;
		job.vy    = vy_q;
	end

endmodule

>>> rtl/rwnh_queue.sv
// Two-entry queue of finished wall walks between the front and the back.
// Depends on rwnh_pkg for the entry type.
module rwnh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rwnh_pkg::job_t din,
	input  logic           pop,
	output rwnh_pkg::job_t dout,
	output logic           full,
	output logic           empty
);

	logic [1:0]     cnt_q;
	logic           wp_q, rp_q;
	rwnh_pkg::job_t entry_q [2];

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = entry_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= din;
		end
	end

endmodule

>>> rtl/rwnh_div.sv
// Restoring divider, one quotient bit per cycle, with overflow and remainder
// flags for saturation and floor rounding. Depends on rwnh_pkg.
module rwnh_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rwnh_pkg::DIV_NUM_W-1:0]   num,
	input  logic [rwnh_pkg::DEN_W-1:0]       den,
	output rwnh_pkg::div_res_t               res
);

	localparam int QW = rwnh_pkg::DIV_Q_W;
	localparam int RW = rwnh_pkg::DIV_NUM_W - QW;

	logic                       busy_q, done_q, ovf_q;
	logic [4:0]                 cnt_q;
	logic [RW-1:0]              rem_q;
	logic [QW-1:0]              nb_q, quo_q;
	logic [rwnh_pkg::DEN_W-1:0] den_q;
	logic [RW:0]                trial;
	logic                       ge;

	assign trial = {rem_q, nb_q[QW-1]};
	assign ge    = (trial >= (RW+1)'(den_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[rwnh_pkg::DIV_NUM_W-1:QW];
			nb_q  <= num[QW-1:0];
			den_q <= den;
			quo_q <= '0;
			// The quotient does not fit when the upper part alone reaches den.
			ovf_q <= (num[rwnh_pkg::DIV_NUM_W-1:QW] >= RW'(den));
		end else if (busy_q) begin
			rem_q <= ge ? RW'(trial - (RW+1)'(den_q)) : trial[RW-1:0];
			nb_q  <= {nb_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign res.done   = done_q;
	assign res.ovf    = ovf_q;
	assign res.rem_nz = (rem_q != '0);
	assign res.quo    = quo_q;

endmodule

>>> rtl/rwnh_back.sv
// Back end: turns the nearest wall of a cast into distance and hit point,
// using three dividers in parallel, and holds the result for the output side.
// Depends on rwnh_pkg and rwnh_div.
module rwnh_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rwnh_pkg::job_t                 job_in,
	input  logic                           queue_empty,
	output logic                           queue_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rwnh_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser
);

	localparam logic [2:0] BK_IDLE = 3'd0;
	localparam logic [2:0] BK_M1   = 3'd1;
	localparam logic [2:0] BK_M2   = 3'd2;
	localparam logic [2:0] BK_M3   = 3'd3;
	localparam logic [2:0] BK_DIV  = 3'd4;
	localparam logic [2:0] BK_WAIT = 3'd5;

	logic [2:0]         state_q;
	rwnh_pkg::job_t     job_q;
	logic signed [31:0] p1_q, p2_q;
	logic signed [32:0] dot_q;
	logic [9:0]         exm_q, eym_q;
	logic [60:0]        dprod_q;
	logic [44:0]        xprod_q, yprod_q;
	logic               dpos_q;
	logic               div_start, out_write, m_tvalid_q;

	rwnh_pkg::div_res_t dres, xres, yres;

	logic [17:0] dist_w, hx_w, hy_w;
	logic [17:0] dist_q, hx_q, hy_q;
	logic [3:0]  wall_q;
	logic        hit_q;

	function automatic logic [17:0] hit_coord(input logic [9:0] base, input logic neg,
		input rwnh_pkg::div_res_t r);
		logic [19:0]        mag;
		logic signed [20:0] off;
		logic signed [20:0] sum;
		// A negative edge rounds toward minus infinity; a positive one truncates.
		mag = {1'b0, r.quo} + 20'(neg && r.rem_nz);
		off = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sum = $signed({3'b0, base, 8'b0}) + off;
		if (sum < 21'sd0) begin
			hit_coord = '0;
		end else if (sum > $signed({3'b0, rwnh_pkg::Q8_MAX})) begin
			hit_coord = rwnh_pkg::Q8_MAX;
		end else begin
			hit_coord = sum[17:0];
		end
	endfunction

	assign queue_pop = (state_q == BK_IDLE) && !queue_empty;
	assign div_start = (state_q == BK_DIV);
	assign out_write = (state_q == BK_WAIT) && dres.done && xres.done && yres.done
		&& (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_write) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (!queue_empty) begin
						state_q <= BK_M1;
					end
				end
				BK_M1:   state_q <= BK_M2;
				BK_M2:   state_q <= BK_M3;
				BK_M3:   state_q <= BK_DIV;
				BK_DIV:  state_q <= BK_WAIT;
				BK_WAIT: begin
					if (out_write) begin
						state_q <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (queue_pop) begin
			job_q <= job_in;
		end
		p1_q    <= job_q.dx * job_q.vx;
		p2_q    <= job_q.dy * job_q.vy;
		exm_q   <= job_q.ex[10] ? 10'(-job_q.ex) : job_q.ex[9:0];
		eym_q   <= job_q.ey[10] ? 10'(-job_q.ey) : job_q.ey[9:0];
		dot_q   <= 33'(p1_q) + 33'(p2_q);
		dpos_q  <= !dot_q[32] && (dot_q != 33'sd0);
		dprod_q <= job_q.nr * dot_q[31:0];
		xprod_q <= exm_q * job_q.nw;
		yprod_q <= eym_q * job_q.nw;
		if (out_write) begin
			hit_q  <= job_q.found;
			dist_q <= job_q.found ? dist_w : '0;
			hx_q   <= job_q.found ? hx_w : '0;
			hy_q   <= job_q.found ? hy_w : '0;
			wall_q <= job_q.found ? job_q.wall : '0;
		end
	end

	rwnh_div u_div_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dprod_q[60:14]),
		.den    (job_q.den),
		.res    (dres)
	);

	rwnh_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (47'(xprod_q)),
		.den    (job_q.den),
		.res    (xres)
	);

	rwnh_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (47'(yprod_q)),
		.den    (job_q.den),
		.res    (yres)
	);

	always_comb begin
		if (!dpos_q) begin
			dist_w = '0;
		end else if (dres.ovf || dres.quo[18]) begin
			dist_w = rwnh_pkg::Q8_MAX;
		end else begin
			dist_w = dres.quo[17:0];
		end
		hx_w = hit_coord(job_q.x1, job_q.ex[10], xres);
		hy_w = hit_coord(job_q.y1, job_q.ey[10], yres);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {6'b0, wall_q, hy_q, hx_q, dist_q};

endmodule

>>> rtl/ray_wall_nearest_hit.sv
// Nearest wall hit of a ray against a loaded table of wall segments.
// A cast walks the walls in use in turn, then the back multiplies and runs its
// 19-step dividers; a queue of two lets the next walk overlap a division.
// Reset clears all control and walls_in_use; the wall table is undefined.
module ray_wall_nearest_hit #(
	parameter int MAX_WALLS = rwnh_pkg::MAX_WALLS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// wall_index, wall_x1, wall_y1, wall_x2, wall_y2, ray_x, ray_y,
	// ray_dx, ray_dy, view_dx, view_dy
	input  logic [rwnh_pkg::S_TDATA_W-1:0] s_tdata,
	// func
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// distance, hit_x, hit_y, hit_wall, zero fill
	output logic [rwnh_pkg::M_TDATA_W-1:0] m_tdata,
	// hit
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rwnh_pkg::CFG_W-1:0]     cfg_data
);

	logic [rwnh_pkg::CFG_W-1:0] walls_in_use_q;
	rwnh_pkg::job_t             q_din, q_dout;
	logic                       q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walls_in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			walls_in_use_q <= cfg_data;
		end
	end

	rwnh_front #(
		.MAX_WALLS (MAX_WALLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.walls_in_use (walls_in_use_q),
		.job          (q_din),
		.job_push     (q_push),
		.queue_full   (q_full)
	);

	rwnh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	rwnh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_in      (q_dout),
		.queue_empty (q_empty),
		.queue_pop   (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

`ifndef SYNTHESIS
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("push into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("pop from an empty queue");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("result without a hit carries nonzero data");
`endif

endmodule

>>> sim/ray_wall_nearest_hit_checker.sv
// Checker for the ray to wall nearest hit block: watches the input, result and
// register channels, predicts each cast result and compares. Depends on rwnh_pkg.
`timescale 1ns / 1ps

module ray_wall_nearest_hit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [rwnh_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [rwnh_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [rwnh_pkg::CFG_W-1:0]     cfg_data,
	output int                             errors,
	output int                             pending
);

	typedef struct packed {
		logic                           hit;
		logic [rwnh_pkg::Q8_W-1:0]      distance;
		logic [rwnh_pkg::Q8_W-1:0]      hit_x;
		logic [rwnh_pkg::Q8_W-1:0]      hit_y;
		logic [rwnh_pkg::WALL_ID_W-1:0] hit_wall;
	} hit_result_t;

	localparam longint Q8_LIMIT = 262143;

	logic [rwnh_pkg::WALL_W-1:0] walls [rwnh_pkg::MAX_WALLS_DEFAULT];
	logic [rwnh_pkg::CFG_W-1:0]  walls_in_use;
	hit_result_t                 expected_hits [$];

	function automatic longint floor_quot(longint num, longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic longint clamp_q8(longint v);
		if (v < 0)
			return 0;
		if (v > Q8_LIMIT)
			return Q8_LIMIT;
		return v;
	endfunction

	function automatic hit_result_t nearest_hit(logic [rwnh_pkg::S_TDATA_W-1:0] d);
		longint rx, ry, dx, dy, vx, vy;
		longint x1, y1, ex, ey, ox, oy, den, nw, nr;
		longint best_nr, best_nw, best_den, dot, perp_dist;
		int count, best;
		bit found;
		hit_result_t r;
		rx = d[61:44];
		ry = d[79:62];
		dx = longint'($signed(d[95:80]));
		dy = longint'($signed(d[111:96]));
		vx = longint'($signed(d[127:112]));
		vy = longint'($signed(d[143:128]));
		count = (walls_in_use > rwnh_pkg::MAX_WALLS_DEFAULT) ? rwnh_pkg::MAX_WALLS_DEFAULT
			: int'(walls_in_use);
		found = 0;
		best = 0;
		best_nr = 0;
		best_nw = 0;
		best_den = 1;
		r = '0;
		for (int j = 0; j < count; j++) begin
			x1 = walls[j][9:0];
			y1 = walls[j][19:10];
			ex = longint'(walls[j][29:20]) - x1;
			ey = longint'(walls[j][39:30]) - y1;
			ox = x1 * 256 - rx;
			oy = y1 * 256 - ry;
			den = dy * ex - dx * ey;
			nw = dx * oy - dy * ox;
			nr = ex * oy - ey * ox;
			if (den == 0)
				continue;
			if (den < 0) begin
				den = -den;
				nw = -nw;
				nr = -nr;
			end
			if (nw <= 0 || nw >= den * 256 || nr <= 0)
				continue;
			// Strict compare keeps the lower index on a tie.
			if (!found || nr * best_den < best_nr * den) begin
				found = 1;
				best = j;
				best_nr = nr;
				best_nw = nw;
				best_den = den;
			end
		end
		if (!found)
			return r;
		dot = dx * vx + dy * vy;
		perp_dist = 0;
		if (dot > 0) begin
			perp_dist = (best_nr * dot) / (best_den * 16384);
			if (perp_dist > Q8_LIMIT)
				perp_dist = Q8_LIMIT;
		end
		x1 = walls[best][9:0];
		y1 = walls[best][19:10];
		ex = longint'(walls[best][29:20]) - x1;
		ey = longint'(walls[best][39:30]) - y1;
		r.hit = 1'b1;
		r.distance = perp_dist[rwnh_pkg::Q8_W-1:0];
		r.hit_x = rwnh_pkg::Q8_W'(clamp_q8(x1 * 256 + floor_quot(ex * best_nw, best_den)));
		r.hit_y = rwnh_pkg::Q8_W'(clamp_q8(y1 * 256 + floor_quot(ey * best_nw, best_den)));
		r.hit_wall = rwnh_pkg::WALL_ID_W'(best);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_result_t got, want;
		if (!arst_n) begin
			walls_in_use <= '0;
			expected_hits.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				walls_in_use <= cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser == rwnh_pkg::FUNC_LOAD)
					walls[s_tdata[3:0]] <= s_tdata[43:4];
				else
					expected_hits = {expected_hits, nearest_hit(s_tdata)};
			end
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser;
				got.distance = m_tdata[17:0];
				got.hit_x = m_tdata[35:18];
				got.hit_y = m_tdata[53:36];
				got.hit_wall = m_tdata[57:54];
				if (expected_hits.size() == 0) begin
					$display("%0t: result with nothing expected: hit=%0d dist=%0d",
						$time, got.hit, got.distance);
					errors <= errors + 1;
				end else begin
					want = expected_hits.pop_front();
					if (got !== want || m_tdata[63:58] !== '0) begin
						$display("%0t: mismatch exp hit=%0d dist=%0d x=%0d y=%0d wall=%0d",
							$time, want.hit, want.distance, want.hit_x, want.hit_y,
							want.hit_wall);
						$display("%0t:          got hit=%0d dist=%0d x=%0d y=%0d wall=%0d",
							$time, got.hit, got.distance, got.hit_x, got.hit_y,
							got.hit_wall);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign pending = expected_hits.size();

endmodule

>>> sim/tb_ray_wall_nearest_hit.sv
// Testbench top for ray_wall_nearest_hit: loads walls, casts directed and random
// rays under varied flow control. Depends on rwnh_pkg and the checker module.
`timescale 1ns / 1ps

module tb_ray_wall_nearest_hit;

	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT  = 20000;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid, s_tready, s_tuser;
	logic [rwnh_pkg::S_TDATA_W-1:0] s_tdata;
	logic                           m_tvalid, m_tready, m_tuser;
	logic [rwnh_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           cfg_valid, cfg_ready;
	logic [rwnh_pkg::CFG_W-1:0]     cfg_data;
	int                             errors, pending;
	int                             send_idle_pct, recv_stall_pct;
	bit                             hold_req;
	int                             quiet_cycles;

	ray_wall_nearest_hit dut (.*);

	ray_wall_nearest_hit_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side flow control, with one long hold-off once it is requested.
	always @(negedge clk) begin
		int hold_left;
		bit hold_started;
		if (hold_req && !hold_started) begin
			hold_started = 1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(logic func, logic [rwnh_pkg::S_TDATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic load_wall(int idx, int x1, int y1, int x2, int y2);
		logic [rwnh_pkg::S_TDATA_W-1:0] d;
		d = {$urandom, $urandom, $urandom, $urandom, $urandom};
		d[3:0] = 4'(idx);
		d[13:4] = 10'(x1);
		d[23:14] = 10'(y1);
		d[33:24] = 10'(x2);
		d[43:34] = 10'(y2);
		send(rwnh_pkg::FUNC_LOAD, d);
	endtask

	task automatic cast_ray(int rx, int ry, int dx, int dy, int vx, int vy);
		logic [rwnh_pkg::S_TDATA_W-1:0] d;
		d = {$urandom, $urandom, $urandom, $urandom, $urandom};
		d[61:44] = 18'(rx);
		d[79:62] = 18'(ry);
		d[95:80] = 16'(dx);
		d[111:96] = 16'(dy);
		d[127:112] = 16'(vx);
		d[143:128] = 16'(vy);
		send(rwnh_pkg::FUNC_CAST, d);
	endtask

	// Registers change only once the block has drained.
	task automatic set_walls_in_use(int n);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= rwnh_pkg::CFG_W'(n);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rand_dir();
		if ($urandom_range(15) == 0)
			return $signed(16'($urandom));
		return $urandom_range(32768) - 16384;
	endfunction

	task automatic random_phase(int items);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 20)
				load_wall($urandom_range(15), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1023));
			else
				cast_ray($urandom_range(262143), $urandom_range(262143), rand_dir(),
					rand_dir(), rand_dir(), rand_dir());
		end
	endtask

	initial begin
		int cfg_seq [8] = '{16, 0, 1, 31, 16, 8, 17, 3};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the whole table before any cast reads it.
		load_wall(0, 512, 0, 512, 1023);
		load_wall(1, 0, 0, 1023, 1023);
		load_wall(2, 800, 100, 800, 900);
		load_wall(3, 800, 100, 800, 900);
		load_wall(4, 1023, 0, 1023, 1023);
		load_wall(5, 0, 1023, 1023, 1023);
		for (int j = 6; j < 16; j++)
			load_wall(j, $urandom_range(1023), $urandom_range(1023),
				$urandom_range(1023), $urandom_range(1023));
		set_walls_in_use(16);
		cast_ray(100 * 256, 500 * 256, 16384, 0, 16384, 0);
		cast_ray(100 * 256, 500 * 256, -16384, 0, 16384, 0);
		cast_ray(600 * 256, 500 * 256, 16384, 0, 16384, 0);
		cast_ray(600 * 256, 500 * 256, 16384, 0, -16384, 0);
		cast_ray(0, 0, 0, 16384, 0, 16384);
		cast_ray(0, 300, 32767, 0, 32767, 0);
		cast_ray(262143, 262143, -32768, -32768, -32768, -32768);
		cast_ray(100 * 256, 300 * 256, 11585, 11585, 0, 16384);
		cast_ray(600 * 256, 50 * 256, 0, 0, 16384, 0);

		for (int p = 0; p < 8; p++) begin
			set_walls_in_use(cfg_seq[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (p == 0)
				hold_req = 1;
			random_phase(115);
		end

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rwnh_pkg.sv
rtl/rwnh_front.sv
rtl/rwnh_queue.sv
rtl/rwnh_div.sv
rtl/rwnh_back.sv
rtl/ray_wall_nearest_hit.sv
sim/ray_wall_nearest_hit_checker.sv
sim/tb_ray_wall_nearest_hit.sv
